// ----- src/arlo_pkg.sv -----
// Shared types, op codes and GF(2^8) helpers for the AES round linear operations block.
package arlo_pkg;

   localparam logic [2:0] OP_ADD_ROUND_KEY = 3'd0;
   localparam logic [2:0] OP_SHIFT_ROWS    = 3'd1;
   localparam logic [2:0] OP_MIX_COLUMNS   = 3'd2;
   localparam logic [2:0] OP_INV_SHIFT     = 3'd3;
   localparam logic [2:0] OP_INV_MIX       = 3'd4;

   localparam logic [7:0] AES_POLY_LOW = 8'h1b;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] state_hi;
      logic [63:0] state_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [3:0]  round_index;
      logic        decrypt;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
      logic [3:0]  round_next;
   } rsp_type;

   // One column of four bytes, element r is row r.
   typedef logic [3:0][7:0] col_type;

   // Sixteen state bytes, element i is state byte i.
   typedef logic [15:0][7:0] bytes_type;

   function automatic logic [7:0] xt(input logic [7:0] b);
      logic [7:0] s;
      s = {b[6:0], 1'b0};
      return b[7] ? (s ^ AES_POLY_LOW) : s;
   endfunction

   // Byte i of the block sits in bits 127-8i down to 120-8i.
   function automatic bytes_type unpack_block(input logic [127:0] blk);
      bytes_type v;
      for (int i = 0; i < 16; i++) begin
         v[i] = blk[127 - 8 * i -: 8];
      end
      return v;
   endfunction

   function automatic logic [127:0] pack_block(input bytes_type v);
      logic [127:0] blk;
      for (int i = 0; i < 16; i++) begin
         blk[127 - 8 * i -: 8] = v[i];
      end
      return blk;
   endfunction

endpackage

// ----- src/aes_round_linear_ops.sv -----
// Top level of the AES round linear operations block: a three-stage pipeline.
// The block applies AddRoundKey, ShiftRows, MixColumns, InvShiftRows or InvMixColumns to a
// 128-bit AES state and takes a new beat in every cycle; busy is always low. The receiver
// cannot hold results off, so nothing inside the pipeline ever stalls. Each beat's result
// appears on rsp_data with rsp_strobe high for one cycle: one register stage captures the
// request, the second holds the row shift or key sum and the GF(2^8) doublings of every byte,
// and the third holds the combined result.
module aes_round_linear_ops (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  arlo_pkg::req_type req_data,
   output logic              rsp_strobe,
   output arlo_pkg::rsp_type rsp_data
);
   import arlo_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_item_ff;

   logic      s2_valid_ff;
   logic [2:0] s2_op_ff;
   logic [3:0] s2_round_ff;
   bytes_type s2_base_ff;
   bytes_type s2_x2_ff;
   bytes_type s2_x4_ff;
   bytes_type s2_x8_ff;
   logic [3:0] s2_round_in;
   bytes_type s2_base_in;
   bytes_type s2_x2_in;
   bytes_type s2_x4_in;
   bytes_type s2_x8_in;

   logic      s3_valid_ff;
   rsp_type   s3_rsp_ff;
   rsp_type   s3_rsp_in;

   bytes_type sb;
   bytes_type mix_fwd;
   bytes_type mix_inv;
   bytes_type s3_bytes;

   assign busy        = 1'b0;
   assign s1_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_item_ff <= req_data;
      end
      s2_op_ff    <= s1_item_ff.op;
      s2_round_ff <= s2_round_in;
      s2_base_ff  <= s2_base_in;
      s2_x2_ff    <= s2_x2_in;
      s2_x4_ff    <= s2_x4_in;
      s2_x8_ff    <= s2_x8_in;
      s3_rsp_ff   <= s3_rsp_in;
   end

   always_comb begin
      sb          = unpack_block({s1_item_ff.state_hi, s1_item_ff.state_lo});
      s2_round_in = s1_item_ff.round_index;
      s2_base_in  = sb;
      for (int i = 0; i < 16; i++) begin
         s2_x2_in[i] = xt(sb[i]);
         s2_x4_in[i] = xt(s2_x2_in[i]);
         s2_x8_in[i] = xt(s2_x4_in[i]);
      end
      unique case (s1_item_ff.op)
         OP_ADD_ROUND_KEY: begin
            s2_base_in = unpack_block({s1_item_ff.state_hi ^ s1_item_ff.key_hi,
                                       s1_item_ff.state_lo ^ s1_item_ff.key_lo});
            s2_round_in = s1_item_ff.decrypt ? (s1_item_ff.round_index - 4'd1)
                                             : (s1_item_ff.round_index + 4'd1);
         end
         OP_SHIFT_ROWS: begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  s2_base_in[r + 4 * c] = sb[r + 4 * ((c + r) % 4)];
               end
            end
         end
         OP_INV_SHIFT: begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  s2_base_in[r + 4 * c] = sb[r + 4 * ((c + 4 - r) % 4)];
               end
            end
         end
         default: begin
            s2_base_in = sb;
         end
      endcase
   end

   for (genvar c = 0; c < 4; c++) begin : g_col
      arlo_mix_column u_mix (
         .a   (s2_base_ff[4 * c +: 4]),
         .a2  (s2_x2_ff[4 * c +: 4]),
         .a4  (s2_x4_ff[4 * c +: 4]),
         .a8  (s2_x8_ff[4 * c +: 4]),
         .fwd (mix_fwd[4 * c +: 4]),
         .inv (mix_inv[4 * c +: 4])
      );
   end

   always_comb begin
      unique case (s2_op_ff)
         OP_MIX_COLUMNS: s3_bytes = mix_fwd;
         OP_INV_MIX:     s3_bytes = mix_inv;
         default:        s3_bytes = s2_base_ff;
      endcase
      {s3_rsp_in.result_hi, s3_rsp_in.result_lo} = pack_block(s3_bytes);
      s3_rsp_in.round_next = s2_round_ff;
   end

   assign rsp_strobe = s3_valid_ff;
   assign rsp_data   = s3_rsp_ff;

endmodule

// ----- src/arlo_mix_column.sv -----
// MixColumns and InvMixColumns of one column from its precomputed GF(2^8) multiples.
module arlo_mix_column (
   input  arlo_pkg::col_type a,
   input  arlo_pkg::col_type a2,
   input  arlo_pkg::col_type a4,
   input  arlo_pkg::col_type a8,
   output arlo_pkg::col_type fwd,
   output arlo_pkg::col_type inv
);
   import arlo_pkg::*;

   col_type m3;
   col_type m9;
   col_type m11;
   col_type m13;
   col_type m14;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         m3[r]  = a2[r] ^ a[r];
         m9[r]  = a8[r] ^ a[r];
         m11[r] = a8[r] ^ a2[r] ^ a[r];
         m13[r] = a8[r] ^ a4[r] ^ a[r];
         m14[r] = a8[r] ^ a4[r] ^ a2[r];
      end
      fwd[0] = a2[0] ^ m3[1] ^ a[2] ^ a[3];
      fwd[1] = a[0] ^ a2[1] ^ m3[2] ^ a[3];
      fwd[2] = a[0] ^ a[1] ^ a2[2] ^ m3[3];
      fwd[3] = m3[0] ^ a[1] ^ a[2] ^ a2[3];
      inv[0] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      inv[1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      inv[2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      inv[3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
   end

endmodule

// ----- tb/arlo_result_checker.sv -----
// Checker for the AES round linear operations block: predicts each result beat and compares it.
module arlo_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  arlo_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  arlo_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import arlo_pkg::*;

   rsp_type predicted_states[$];
   int      mismatches = 0;
   int      issued = 0;
   int      retired = 0;

   assign error_count = mismatches;
   assign outstanding = issued - retired;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] k);
      logic [7:0] acc;
      logic [7:0] dbl;
      acc = 8'h00;
      dbl = a;
      for (int b = 0; b < 4; b++) begin
         if (k[b]) begin
            acc = acc ^ dbl;
         end
         dbl = {dbl[6:0], 1'b0} ^ (dbl[7] ? AES_POLY_LOW : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [3:0] mix_coef(input logic inverse, input int offset);
      logic [3:0] k;
      unique case (offset % 4)
         0: k = inverse ? 4'he : 4'h2;
         1: k = inverse ? 4'hb : 4'h3;
         2: k = inverse ? 4'hd : 4'h1;
         default: k = inverse ? 4'h9 : 4'h1;
      endcase
      return k;
   endfunction

   function automatic rsp_type apply_round_op(input req_type beat);
      logic [7:0]   src [16];
      logic [7:0]   dst [16];
      logic [7:0]   acc;
      logic [127:0] blk;
      logic [127:0] kblk;
      int           col;
      rsp_type      res;
      blk = {beat.state_hi, beat.state_lo};
      kblk = {beat.key_hi, beat.key_lo};
      for (int i = 0; i < 16; i++) begin
         src[i] = blk[127 - 8 * i -: 8];
         dst[i] = src[i];
      end
      res.round_next = beat.round_index;
      case (beat.op)
         OP_ADD_ROUND_KEY: begin
            for (int i = 0; i < 16; i++) begin
               dst[i] = src[i] ^ kblk[127 - 8 * i -: 8];
            end
            res.round_next = beat.decrypt ? beat.round_index - 4'd1 : beat.round_index + 4'd1;
         end
         OP_SHIFT_ROWS, OP_INV_SHIFT: begin
            for (int c = 0; c < 4; c++) begin
               for (int row = 0; row < 4; row++) begin
                  col = (beat.op == OP_SHIFT_ROWS) ? (c + row) % 4 : (c + 4 - row) % 4;
                  dst[row + 4 * c] = src[row + 4 * col];
               end
            end
         end
         OP_MIX_COLUMNS, OP_INV_MIX: begin
            for (int c = 0; c < 4; c++) begin
               for (int row = 0; row < 4; row++) begin
                  acc = 8'h00;
                  for (int j = 0; j < 4; j++) begin
                     acc = acc ^ gf_mul(src[4 * c + j],
                                        mix_coef(beat.op == OP_INV_MIX, j - row + 4));
                  end
                  dst[4 * c + row] = acc;
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 16; i++) begin
         blk[127 - 8 * i -: 8] = dst[i];
      end
      res.result_hi = blk[127:64];
      res.result_lo = blk[63:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_states.size() == 0) begin
               $error("result beat with no expected result");
               mismatches = mismatches + 1;
            end else begin
               want = predicted_states.pop_front();
               retired <= retired + 1;
               if (rsp_data.result_hi !== want.result_hi) begin
                  $error("result_hi expected %h actual %h", want.result_hi, rsp_data.result_hi);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.result_lo !== want.result_lo) begin
                  $error("result_lo expected %h actual %h", want.result_lo, rsp_data.result_lo);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.round_next !== want.round_next) begin
                  $error("round_next expected %0d actual %0d", want.round_next,
                         rsp_data.round_next);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (start && !busy) begin
            predicted_states.push_back(apply_round_op(req_data));
            issued <= issued + 1;
         end
      end
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the AES round linear operations block: stimulus, checker hookup and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arlo_pkg::*;

   localparam int         RANDOM_BEATS    = 1450;
   localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI  = 3'd7;
   localparam logic [63:0] ALL_ONES       = 64'hffff_ffff_ffff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      error_count;
   int      outstanding;

   always #2 clock = ~clock;

   aes_round_linear_ops u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   arlo_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   function automatic req_type build_beat(input logic [2:0] op, input logic [63:0] shi,
                                          input logic [63:0] slo, input logic [63:0] khi,
                                          input logic [63:0] klo, input logic [3:0] rnd,
                                          input logic dec);
      req_type beat;
      beat.op = op;
      beat.state_hi = shi;
      beat.state_lo = slo;
      beat.key_hi = khi;
      beat.key_lo = klo;
      beat.round_index = rnd;
      beat.decrypt = dec;
      return beat;
   endfunction

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      case ($urandom_range(0, 11))
         0: w = '0;
         1: w = ALL_ONES;
         2: w = {8{8'h80}};
         3: w = {8{8'h7f}};
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic req_type random_beat();
      logic [2:0] op;
      op = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
      return build_beat(op, rand_word(), rand_word(), rand_word(), rand_word(),
                        4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_beat(input req_type beat);
      start <= 1'b1;
      req_data <= beat;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      bit pressure_done;
      sent = 0;
      pressure_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(build_beat(OP_ADD_ROUND_KEY, '0, '0, ALL_ONES, ALL_ONES, 4'd15, 1'b0));
      send_beat(build_beat(OP_ADD_ROUND_KEY, ALL_ONES, ALL_ONES, 64'h0123_4567_89ab_cdef,
                           64'hfedc_ba98_7654_3210, 4'd0, 1'b1));
      send_beat(build_beat(OP_ADD_ROUND_KEY, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
                           64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 4'd7, 1'b0));
      send_beat(build_beat(OP_ADD_ROUND_KEY, ALL_ONES, '0, ALL_ONES, '0, 4'd8, 1'b1));
      idle_for(2);
      send_beat(build_beat(OP_SHIFT_ROWS, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                           ALL_ONES, ALL_ONES, 4'd15, 1'b1));
      send_beat(build_beat(OP_INV_SHIFT, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                           ALL_ONES, ALL_ONES, 4'd0, 1'b0));
      send_beat(build_beat(OP_SHIFT_ROWS, ALL_ONES, '0, '0, '0, 4'd3, 1'b0));
      send_beat(build_beat(OP_INV_SHIFT, '0, ALL_ONES, '0, '0, 4'd12, 1'b1));
      send_beat(build_beat(OP_MIX_COLUMNS, 64'hdb13_5345_f20a_225c, 64'h0101_0101_c6c6_c6c6,
                           ALL_ONES, '0, 4'd15, 1'b0));
      send_beat(build_beat(OP_MIX_COLUMNS, {8{8'h80}}, ALL_ONES, '0, ALL_ONES, 4'd0, 1'b1));
      send_beat(build_beat(OP_MIX_COLUMNS, '0, '0, ALL_ONES, ALL_ONES, 4'd5, 1'b0));
      idle_for(1);
      send_beat(build_beat(OP_INV_MIX, 64'h8e4d_a1bc_9fdc_589d, 64'h0101_0101_c6c6_c6c6,
                           '0, ALL_ONES, 4'd15, 1'b1));
      send_beat(build_beat(OP_INV_MIX, {8{8'h80}}, ALL_ONES, ALL_ONES, '0, 4'd0, 1'b0));
      send_beat(build_beat(OP_INV_MIX, '0, {8{8'h7f}}, '0, '0, 4'd9, 1'b1));
      for (logic [3:0] k = 4'(OP_RESERVED_LO); k <= 4'(OP_RESERVED_HI); k++) begin
         send_beat(build_beat(k[2:0], 64'h0123_4567_89ab_cdef, ALL_ONES, ALL_ONES, ALL_ONES,
                              4'd15, 1'b0));
         send_beat(build_beat(k[2:0], ALL_ONES, '0, ALL_ONES, ALL_ONES, 4'd0, 1'b1));
      end
      wait_quiet();

      while (sent < RANDOM_BEATS) begin
         burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
            send_beat(random_beat());
            sent++;
         end
         if (!pressure_done && sent >= RANDOM_BEATS / 2) begin
            wait_quiet();
            pressure_done = 1'b1;
         end
         idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
